// ----- rtl/hull_clearance_check_assert.svh -----
`ifndef HULL_CLEARANCE_CHECK_ASSERT_SVH
`define HULL_CLEARANCE_CHECK_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define HCC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hull clearance check: assertion failed");

// Condition implies consequence in the next cycle.
`define HCC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hull clearance check: assertion failed");

`endif

// ----- rtl/hcc_pkg.sv -----
package hcc_pkg;

  localparam int NUM_HIP_REGS = 8;
  localparam int SINE_STEPS   = 5;
  localparam int ROT_OPS      = 8;

  localparam logic [30:0] SINE_C11 = 31'd3864;
  localparam logic [30:0] SINE_COEF [SINE_STEPS] =
    '{31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713};

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SIN_INIT,
    OP_SIN_STEP,
    OP_SIN_END,
    OP_ROT_X,
    OP_ROT_Y,
    OP_DOT,
    OP_OBS,
    OP_FINAL
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIN,
    S_COS,
    S_ROT,
    S_DIR,
    S_DRAIN,
    S_FINAL
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
    logic       first;
    logic       sel_cos;
  } cmd_t;

  typedef struct packed {
    logic feet;
    logic out_free;
  } status_t;

  // Elaboration-time sine in Q16, same polynomial as the datapath unit.
  function automatic logic signed [17:0] sine_const(input logic [15:0] p);
    longint unsigned r;
    longint unsigned x2;
    longint unsigned s;
    longint unsigned y;
    longint unsigned v;
    r = p[14] ? (64'd16384 - 64'(p[13:0])) : 64'(p[13:0]);
    x2 = r * r * 4;
    s = 64'(SINE_C11);
    for (int j = 0; j < SINE_STEPS; j++) begin
      s = 64'(SINE_COEF[j]) - ((x2 * s) >> 30);
    end
    y = (r * s) >> 14;
    v = (y + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return p[15] ? -18'(v) : 18'(v);
  endfunction

endpackage

// ----- rtl/hcc_ctrl.sv -----
module hcc_ctrl import hcc_pkg::*; #(
  parameter int NUM_DIRECTIONS = 64,
  parameter int DIR_W = $clog2(NUM_DIRECTIONS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  status_t          status,
  output cmd_t             cmd,
  output logic [DIR_W-1:0] dir
);

  localparam logic [DIR_W-1:0] LAST_DIR = DIR_W'(NUM_DIRECTIONS - 1);

  state_t           state, state_next;
  logic [2:0]       cnt, cnt_next;
  logic [DIR_W-1:0] dir_next;
  logic [2:0]       npts;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      dir   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      dir   <= dir_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    dir_next   = dir;
    cmd        = '{op: OP_NONE, idx: 3'd0, first: 1'b0, sel_cos: 1'b0};
    in_stall   = 1'b1;
    npts       = status.feet ? 3'd6 : 3'd4;
    unique case (state) inside
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          cnt_next   = '0;
          state_next = S_SIN;
        end
      end
      S_SIN, S_COS: begin
        cmd.sel_cos = (state == S_COS);
        cnt_next    = cnt + 3'd1;
        if (cnt == 3'd0) begin
          cmd.op = OP_SIN_INIT;
        end else if (cnt == 3'(SINE_STEPS + 1)) begin
          cmd.op     = OP_SIN_END;
          cnt_next   = '0;
          state_next = (state == S_SIN) ? S_COS : S_ROT;
        end else begin
          cmd.op  = OP_SIN_STEP;
          cmd.idx = cnt - 3'd1;
        end
      end
      S_ROT: begin
        cmd.op   = cnt[0] ? OP_ROT_Y : OP_ROT_X;
        cmd.idx  = {1'b0, cnt[2:1]};
        cnt_next = cnt + 3'd1;
        if (cnt == 3'(ROT_OPS - 1)) begin
          cnt_next   = '0;
          dir_next   = '0;
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        if (cnt != npts) begin
          cmd.op   = OP_DOT;
          cmd.idx  = cnt;
          cnt_next = cnt + 3'd1;
        end else begin
          cmd.op    = OP_OBS;
          cmd.first = (dir == '0);
          cnt_next  = '0;
          if (dir == LAST_DIR) begin
            state_next = S_DRAIN;
          end else begin
            dir_next = dir + DIR_W'(1);
          end
        end
      end
      S_DRAIN: begin
        state_next = S_FINAL;
      end
      S_FINAL: begin
        if (status.out_free) begin
          cmd.op     = OP_FINAL;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/hcc_dp.sv -----
module hcc_dp import hcc_pkg::*; #(
  parameter int NUM_DIRECTIONS = 64,
  parameter int DIR_W = $clog2(NUM_DIRECTIONS)
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [DIR_W-1:0]   dir,
  output status_t            status,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic signed [23:0] centre_x,
  input  logic signed [23:0] centre_y,
  input  logic [15:0]        heading,
  input  logic               feet_present,
  input  logic signed [23:0] foot_a_x,
  input  logic signed [23:0] foot_a_y,
  input  logic signed [23:0] foot_b_x,
  input  logic signed [23:0] foot_b_y,
  input  logic signed [23:0] obstacle_x,
  input  logic signed [23:0] obstacle_y,
  input  logic signed [23:0] min_clearance,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               collides,
  output logic signed [25:0] clearance
);

  logic signed [17:0] dir_cos [NUM_DIRECTIONS];
  logic signed [17:0] dir_sin [NUM_DIRECTIONS];

  for (genvar g = 0; g < NUM_DIRECTIONS; g++) begin : g_dir
    localparam logic [15:0] PH =
      16'(((g * 65536) + NUM_DIRECTIONS / 2) / NUM_DIRECTIONS);
    assign dir_cos[g] = sine_const(PH + 16'd16384);
    assign dir_sin[g] = sine_const(PH);
  end

  logic signed [23:0] hip [NUM_HIP_REGS];
  logic signed [26:0] cx, cy, ox, oy;
  logic signed [23:0] dmin;
  logic [15:0]        hd;
  logic               feet;
  logic signed [26:0] px [6];
  logic signed [26:0] py [6];

  logic [14:0]        rr;
  logic               neg;
  logic [30:0]        x2, s;
  logic signed [17:0] hs, hc;
  logic [15:0]        phase;
  logic [13:0]        r_low;
  logic [14:0]        r_fold;
  logic [29:0]        r_sq;
  logic [30:0]        sm_a;
  logic [61:0]        sm_prod;
  logic [31:0]        y;
  logic [31:0]        q16;
  logic [16:0]        mag;

  logic signed [26:0] ma1, ma2;
  logic signed [17:0] mb1, mb2;
  logic signed [44:0] p1, p2;
  op_t                op_q;
  logic [2:0]         idx_q;
  logic               first_q;
  logic signed [45:0] psum, pdiff, rsum;
  logic signed [29:0] rnd;
  logic signed [47:0] sup, best, val;
  logic signed [47:0] best_r;
  logic signed [31:0] clr;

  assign status.feet     = feet;
  assign status.out_free = !out_valid || !out_stall;

  // Sine unit: one Horner step per cycle.
  assign phase   = hd + (cmd.sel_cos ? 16'd16384 : 16'd0);
  assign r_low   = phase[13:0];
  assign r_fold  = phase[14] ? (15'd16384 - {1'b0, r_low}) : {1'b0, r_low};
  assign r_sq    = r_fold * r_fold;
  assign sm_a    = (cmd.op == OP_SIN_STEP) ? x2 : {16'd0, rr};
  assign sm_prod = sm_a * s;
  assign y       = sm_prod[45:14];
  assign q16     = (y + 32'd8192) >> 14;
  assign mag     = (q16 > 32'd65536) ? 17'd65536 : q16[16:0];

  always_comb begin
    ma1 = '0;
    ma2 = '0;
    mb1 = '0;
    mb2 = '0;
    case (cmd.op)
      OP_ROT_X: begin
        ma1 = 27'(hip[{cmd.idx[1:0], 1'b0}]);
        ma2 = 27'(hip[{cmd.idx[1:0], 1'b1}]);
        mb1 = hc;
        mb2 = hs;
      end
      OP_ROT_Y: begin
        ma1 = 27'(hip[{cmd.idx[1:0], 1'b0}]);
        ma2 = 27'(hip[{cmd.idx[1:0], 1'b1}]);
        mb1 = hs;
        mb2 = hc;
      end
      OP_DOT: begin
        ma1 = px[cmd.idx];
        ma2 = py[cmd.idx];
        mb1 = dir_cos[dir];
        mb2 = dir_sin[dir];
      end
      OP_OBS: begin
        ma1 = ox;
        ma2 = oy;
        mb1 = dir_cos[dir];
        mb2 = dir_sin[dir];
      end
      default: begin
      end
    endcase
  end

  assign psum   = 46'(p1) + 46'(p2);
  assign pdiff  = 46'(p1) - 46'(p2);
  assign rsum   = ((op_q == OP_ROT_X) ? pdiff : psum) + 46'sd32768;
  assign rnd    = 30'(rsum >>> 16);
  assign val    = 48'(psum) - sup;
  assign best_r = best + 48'sd32768;
  assign clr    = 32'(best_r >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HIP_REGS; i++) begin
        hip[i] <= '0;
      end
      out_valid <= 1'b0;
      op_q      <= OP_NONE;
    end else begin
      if (cfg_we && (cfg_index < 4'(NUM_HIP_REGS))) begin
        hip[cfg_index[2:0]] <= cfg_data;
      end
      if (cmd.op == OP_FINAL) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      op_q <= cmd.op;
    end
  end

  always_ff @(posedge clk) begin
    p1      <= ma1 * mb1;
    p2      <= ma2 * mb2;
    idx_q   <= cmd.idx;
    first_q <= cmd.first;
    case (cmd.op)
      OP_LOAD: begin
        cx    <= 27'(centre_x);
        cy    <= 27'(centre_y);
        ox    <= 27'(obstacle_x);
        oy    <= 27'(obstacle_y);
        dmin  <= min_clearance;
        hd    <= heading;
        feet  <= feet_present;
        px[4] <= 27'(foot_a_x);
        py[4] <= 27'(foot_a_y);
        px[5] <= 27'(foot_b_x);
        py[5] <= 27'(foot_b_y);
      end
      OP_SIN_INIT: begin
        rr  <= r_fold;
        neg <= phase[15];
        x2  <= {r_sq[28:0], 2'b00};
        s   <= SINE_C11;
      end
      OP_SIN_STEP: begin
        s <= SINE_COEF[cmd.idx] - sm_prod[60:30];
      end
      OP_SIN_END: begin
        if (cmd.sel_cos) begin
          hc <= neg ? -18'(mag) : 18'(mag);
        end else begin
          hs <= neg ? -18'(mag) : 18'(mag);
        end
      end
      OP_FINAL: begin
        collides <= (clr < 32'(dmin));
        if (clr > 32'sd33554431) begin
          clearance <= 26'sd33554431;
        end else if (clr < -32'sd33554432) begin
          clearance <= -26'sd33554432;
        end else begin
          clearance <= clr[25:0];
        end
      end
      default: begin
      end
    endcase
    case (op_q)
      OP_ROT_X: px[idx_q] <= cx + 27'(rnd);
      OP_ROT_Y: py[idx_q] <= cy + 27'(rnd);
      OP_DOT: begin
        if ((idx_q == 3'd0) || (48'(psum) > sup)) begin
          sup <= 48'(psum);
        end
      end
      OP_OBS: begin
        if (first_q || (val > best)) begin
          best <= val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/hull_clearance_check.sv -----
// Channel   Handshake             Payload
// request   in_valid / in_stall   centre, heading, feet, obstacle, min_clearance
// result    out_valid / out_stall collides, clearance
// config    cfg_we                cfg_index, cfg_data
//
// Per direction a request runs P dot products and one obstacle projection,
// P being 4 hull points, or 6 with feet, on the shared pair of multipliers.
// Heading sine and cosine are each computed in turn by the iterative sine unit.
// Reset is synchronous and clears the controller, the hip offsets and out_valid.
// A waiting result does not block the next request; only the final write waits.
module hull_clearance_check import hcc_pkg::*; #(
  parameter int NUM_DIRECTIONS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] centre_x,
  input  logic signed [23:0] centre_y,
  input  logic [15:0]        heading,
  input  logic               feet_present,
  input  logic signed [23:0] foot_a_x,
  input  logic signed [23:0] foot_a_y,
  input  logic signed [23:0] foot_b_x,
  input  logic signed [23:0] foot_b_y,
  input  logic signed [23:0] obstacle_x,
  input  logic signed [23:0] obstacle_y,
  input  logic signed [23:0] min_clearance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               collides,
  output logic signed [25:0] clearance
);

  localparam int DIR_W = $clog2(NUM_DIRECTIONS);

  cmd_t             cmd;
  status_t          status;
  logic [DIR_W-1:0] dir;

  hcc_ctrl #(
    .NUM_DIRECTIONS(NUM_DIRECTIONS),
    .DIR_W(DIR_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status(status),
    .cmd(cmd),
    .dir(dir)
  );

  hcc_dp #(
    .NUM_DIRECTIONS(NUM_DIRECTIONS),
    .DIR_W(DIR_W)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .dir(dir),
    .status(status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .centre_x(centre_x),
    .centre_y(centre_y),
    .heading(heading),
    .feet_present(feet_present),
    .foot_a_x(foot_a_x),
    .foot_a_y(foot_a_y),
    .foot_b_x(foot_b_x),
    .foot_b_y(foot_b_y),
    .obstacle_x(obstacle_x),
    .obstacle_y(obstacle_y),
    .min_clearance(min_clearance),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .collides(collides),
    .clearance(clearance)
  );

endmodule

// ----- rtl/hcc_checker.sv -----
`include "hull_clearance_check_assert.svh"

module hcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               collides,
  input logic signed [25:0] clearance
);

  `HCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(clearance))
  `HCC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `HCC_ASSERT_NOW(a_low_sat_collides, out_valid && (clearance == -26'sd33554432), collides)
  `HCC_ASSERT_NOW(a_high_sat_clear, out_valid && (clearance == 26'sd33554431), !collides)

endmodule

bind hull_clearance_check hcc_checker u_hcc_checker (.*);
